/* rtl/core/sequential_list_table_unit_macros.svh */
// Assertion macros for the sequential list table unit.
// Used at the end of the top level; expects clk and rst in scope.
`ifndef SEQUENTIAL_LIST_TABLE_UNIT_MACROS_SVH
`define SEQUENTIAL_LIST_TABLE_UNIT_MACROS_SVH

// Condition holds at every edge out of reset.
`define SLT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/slt_pkg.sv */
// Package for the sequential list table unit: opcodes, status codes, field widths.
// No dependencies.
package slt_pkg;

  localparam int OpW     = 2;
  localparam int PosW    = 5;
  localparam int ValW    = 32;
  localparam int StatusW = 2;
  localparam int InDataW  = 72;
  localparam int OutDataW = 16;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_SEARCH = 2'd2;
  localparam logic [OpW-1:0] OP_UPDATE = 2'd3;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

endpackage

/* rtl/core/sequential_list_table_unit.sv */
// Top level of the sequential list table unit: ordered list store with a move/scan sequencer.
// Depends on slt_pkg and sequential_list_table_unit_macros.svh.

// Ordered list of signed 32-bit values in a CAPACITY-entry store. Each input beat carries
// an opcode: insert at a 1-based position, delete at a position, search for the first
// match, or update the first match. One beat is handled at a time. After acceptance the
// store is walked one entry per cycle, one read and one write a cycle: insert moves
// count-position+1 entries, delete moves count-position entries, search and update read
// up to count entries and stop at the first match. Bad-position and full results skip the
// walk. The unit is ready for the next beat in the same cycle as the result goes valid. The
// result is held in an output register, so a waiting result does not block the next
// input beat, only the delivery of that beat's result. Entries are never read before
// they are written, so the store has no clearing pass.
module sequential_list_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] opcode, [6:2] position, [38:7] value, [70:39] new_value, [71] zero
  input  logic [slt_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [6:2] found_position, [11:7] entry_count, [15:12] zero
  output logic [slt_pkg::OutDataW-1:0]  m_tdata
);
  import slt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > PosW) ? CW : PosW) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       count;
  logic [AW-1:0]       rd_ptr;
  logic [AW-1:0]       rd_addr;
  logic [CW-1:0]       rd_left;
  logic                rvalid;
  logic [ValW-1:0]     rd_data;
  logic [ValW-1:0]     mem [CAPACITY];

  logic [OpW-1:0]      op;
  logic [PosW-1:0]     pos;
  logic [ValW-1:0]     val;
  logic [ValW-1:0]     nval;
  logic [StatusW-1:0]  res_status;
  logic [CW-1:0]       res_found;

  logic [OpW-1:0]      in_op;
  logic [PosW-1:0]     in_pos;
  logic [XW-1:0]       in_pos_x;
  logic [XW-1:0]       cnt_x;
  logic [XW-1:0]       pos_x;
  logic                in_bad;
  logic                in_full;
  logic [StatusW-1:0]  in_status;
  logic                accept;

  logic                is_scan;
  logic                issue;
  logic                hit;
  logic                drained;
  logic                finish;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [ValW-1:0]     mem_wd;

  logic                done_full;
  logic                done_scan;

  assign in_op    = s_tdata[1:0];
  assign in_pos   = s_tdata[6:2];
  assign in_pos_x = XW'(in_pos);
  assign cnt_x    = XW'(count);
  assign pos_x    = XW'(pos);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Range checks on the incoming beat; position check wins over full.
  always_comb begin
    in_bad  = 1'b0;
    in_full = 1'b0;
    case (in_op)
      OP_INSERT: begin
        in_bad  = (in_pos == '0) || (in_pos_x > cnt_x + XW'(1));
        in_full = (cnt_x == XW'(CAPACITY));
      end
      OP_DELETE: begin
        in_bad = (in_pos == '0) || (in_pos_x > cnt_x);
      end
      default: begin
        in_bad = 1'b0;
      end
    endcase
    if (in_bad) begin
      in_status = ST_BAD_POS;
    end else if (in_full) begin
      in_status = ST_FULL;
    end else begin
      in_status = ST_OK;
    end
  end

  assign is_scan = (op == OP_SEARCH) || (op == OP_UPDATE);
  assign issue   = (rd_left != '0);
  assign hit     = is_scan && rvalid && (rd_data == val);
  assign drained = !issue && !rvalid;
  assign finish  = hit || drained;

  // Single write port: moved entry, inserted value, or replacement.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr;
    mem_wd = rd_data;
    if (state == S_RUN) begin
      case (op)
        OP_INSERT: begin
          mem_we = rvalid || drained;
          mem_wa = rvalid ? rd_addr + AW'(1) : AW'(pos_x - XW'(1));
          mem_wd = rvalid ? rd_data : val;
        end
        OP_DELETE: begin
          mem_we = rvalid;
          mem_wa = rd_addr - AW'(1);
          mem_wd = rd_data;
        end
        OP_UPDATE: begin
          mem_we = hit;
          mem_wa = rd_addr;
          mem_wd = nval;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_ptr];
    rd_addr <= rd_ptr;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rvalid   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rvalid <= 1'b0;
          if (accept) begin
            state <= (in_bad || in_full) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          // Drop a read in flight once the walk ends.
          rvalid <= issue && !finish;
          if (finish) begin
            state <= S_DONE;
            if (op == OP_INSERT) begin
              count <= count + CW'(1);
            end else if (op == OP_DELETE) begin
              count <= count - CW'(1);
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: beat fields, walk pointers, result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op         <= in_op;
          pos        <= in_pos;
          val        <= s_tdata[38:7];
          nval       <= s_tdata[70:39];
          res_status <= in_status;
          res_found  <= '0;
          case (in_op)
            OP_INSERT: begin
              rd_ptr  <= AW'(cnt_x - XW'(1));
              rd_left <= CW'(cnt_x - in_pos_x + XW'(1));
            end
            OP_DELETE: begin
              rd_ptr  <= AW'(in_pos_x);
              rd_left <= CW'(cnt_x - in_pos_x);
            end
            default: begin
              rd_ptr  <= '0;
              rd_left <= count;
            end
          endcase
        end
      end
      S_RUN: begin
        if (issue) begin
          rd_ptr  <= (op == OP_INSERT) ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
          rd_left <= rd_left - CW'(1);
        end
        if (hit) begin
          res_found <= CW'(rd_addr) + CW'(1);
        end else if (drained && is_scan) begin
          res_status <= ST_NOT_FOUND;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {4'b0, 5'(count), 5'(res_found), res_status};
        end
      end
      default: begin
        rd_left <= '0;
      end
    endcase
  end

  assign done_full = (state == S_DONE) && (res_status == ST_FULL);
  assign done_scan = (state == S_DONE) && is_scan;

`include "sequential_list_table_unit_macros.svh"

  `SLT_ASSERT_ALWAYS(a_count_range, (count <= CW'(CAPACITY)), "count above capacity")
  `SLT_ASSERT_IMPL(a_rvalid_run, rvalid, (state == S_RUN), "read in flight outside walk")
  `SLT_ASSERT_IMPL(a_full_count, done_full, (count == CW'(CAPACITY)), "full below capacity")
  `SLT_ASSERT_IMPL(a_found_ok, done_scan, ((res_status == ST_OK) == (res_found != '0)), "bad hit")

endmodule

/* tb/tb_sequential_list_table_unit.sv */
// Self-checking testbench for sequential_list_table_unit: directed table, then random ops.
// Depends on slt_pkg and the unit RTL; the expected results come from a list predictor below.
`timescale 1ns / 100ps

module tb_sequential_list_table_unit;
  import slt_pkg::*;

  localparam int CAP        = 16;
  localparam int RAND_ITEMS = 1100;
  localparam int STALL_MAX  = 5000;
  localparam int TAIL_WAIT  = 40;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    found;
    logic [PosW-1:0]    count;
  } list_result_t;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [PosW-1:0]    pos;
    logic [ValW-1:0]    val;
    logic [ValW-1:0]    nval;
    int                 reps;
    bit                 chk;
    logic [StatusW-1:0] st;
    logic [PosW-1:0]    fp;
    logic [PosW-1:0]    cnt;
  } list_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  logic [ValW-1:0] list_mem [CAP];
  int              list_len;
  list_result_t    pending_results [$];
  int              mismatches;
  int              src_idle_pct;
  int              sink_idle_pct;
  int              stall_cycles;

  logic [ValW-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
                                      32'h1234_5678, 32'hA5A5_A5A5};

  // Rows with chk set carry their result typed in; the rest use the predictor.
  list_row_t directed_rows [26] = '{
    '{OP_SEARCH, 5'd0,  32'h0000_0000, 32'h0,          1,  1'b1, ST_NOT_FOUND, 5'd0, 5'd0},
    '{OP_UPDATE, 5'd0,  32'h7FFF_FFFF, 32'h1,          1,  1'b1, ST_NOT_FOUND, 5'd0, 5'd0},
    '{OP_DELETE, 5'd1,  32'h0,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd0},
    '{OP_DELETE, 5'd0,  32'h0,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd0},
    '{OP_INSERT, 5'd0,  32'h5,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd0},
    '{OP_INSERT, 5'd2,  32'h5,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd0},
    '{OP_INSERT, 5'd1,  32'h8000_0000, 32'h0,          1,  1'b1, ST_OK,        5'd0, 5'd1},
    '{OP_INSERT, 5'd2,  32'h7FFF_FFFF, 32'h0,          1,  1'b1, ST_OK,        5'd0, 5'd2},
    '{OP_INSERT, 5'd1,  32'hFFFF_FFFF, 32'h0,          1,  1'b1, ST_OK,        5'd0, 5'd3},
    '{OP_SEARCH, 5'd0,  32'h7FFF_FFFF, 32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_UPDATE, 5'd0,  32'h8000_0000, 32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_SEARCH, 5'd0,  32'h0,         32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_DELETE, 5'd31, 32'h0,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd3},
    '{OP_DELETE, 5'd4,  32'h0,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd3},
    '{OP_DELETE, 5'd2,  32'h0,         32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_INSERT, 5'd3,  32'h5A5A_5A5A, 32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_INSERT, 5'd2,  32'h0000_1000, 32'h0,          13, 1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_INSERT, 5'd17, 32'h1,         32'h0,          1,  1'b1, ST_FULL,      5'd0, 5'd16},
    '{OP_INSERT, 5'd1,  32'h1,         32'h0,          1,  1'b1, ST_FULL,      5'd0, 5'd16},
    '{OP_INSERT, 5'd18, 32'h1,         32'h0,          1,  1'b1, ST_BAD_POS,   5'd0, 5'd16},
    '{OP_SEARCH, 5'd0,  32'h5A5A_5A5A, 32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_UPDATE, 5'd0,  32'h5A5A_5A5A, 32'hFFFF_FFFF,  1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_SEARCH, 5'd0,  32'hFFFF_FFFF, 32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_DELETE, 5'd16, 32'h0,         32'h0,          1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_DELETE, 5'd1,  32'h0,         32'h0,          15, 1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_SEARCH, 5'd0,  32'h0,         32'h0,          1,  1'b1, ST_NOT_FOUND, 5'd0, 5'd0}
  };

  sequential_list_table_unit #(.CAPACITY(CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the list copy and return the result it yields.
  function automatic list_result_t apply_list_op(input logic [OpW-1:0] op,
                                                 input logic [PosW-1:0] pos,
                                                 input logic [ValW-1:0] val,
                                                 input logic [ValW-1:0] nval);
    list_result_t r;
    int hit;
    r.status = ST_OK;
    r.found  = '0;
    hit      = 0;
    if (op == OP_INSERT) begin
      if (pos < 1 || pos > list_len + 1) begin
        r.status = ST_BAD_POS;
      end else if (list_len >= CAP) begin
        r.status = ST_FULL;
      end else begin
        for (int i = list_len; i >= pos; i--) list_mem[i] = list_mem[i-1];
        list_mem[pos-1] = val;
        list_len++;
      end
    end else if (op == OP_DELETE) begin
      if (pos < 1 || pos > list_len) begin
        r.status = ST_BAD_POS;
      end else begin
        for (int i = pos; i < list_len; i++) list_mem[i-1] = list_mem[i];
        list_len--;
      end
    end else begin
      for (int i = 0; i < list_len; i++) begin
        if (list_mem[i] == val) begin
          hit = i + 1;
          break;
        end
      end
      r.found = PosW'(hit);
      if (hit == 0) begin
        r.status = ST_NOT_FOUND;
      end else if (op == OP_UPDATE) begin
        list_mem[hit-1] = nval;
      end
    end
    r.count = PosW'(list_len);
    return r;
  endfunction

  // Drive one beat, hold it until taken, then record what should come back.
  task automatic send_list_op(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                              input logic [ValW-1:0] val, input logic [ValW-1:0] nval,
                              input bit chk, input list_result_t typed);
    list_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, nval, val, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_list_op(op, pos, val, nval);
    pending_results.push_back(chk ? typed : r);
  endtask

  // Result side: random backpressure and in-order comparison.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no operation pending: %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            mismatches++;
          end
          if (m_tdata[6:2] !== want.found) begin
            $error("found_position: expected %0d, got %0d", want.found, m_tdata[6:2]);
            mismatches++;
          end
          if (m_tdata[11:7] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, m_tdata[11:7]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    list_result_t    typed;
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    logic [ValW-1:0] nval;
    int              mode;
    int              w;
    int              ins_th;
    int              del_th;

    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    list_len      = 0;
    src_idle_pct  = 10;
    sink_idle_pct = 58;
    mode          = MODE_MIXED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      typed = '{directed_rows[r].st, directed_rows[r].fp, directed_rows[r].cnt};
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_list_op(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val + k,
                     directed_rows[r].nval, directed_rows[r].chk, typed);
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        src_idle_pct  = 58;
        sink_idle_pct = 10;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      // Every 60 items pick a growth, shrink or mixed run at random, so the list swings between empty and full.
      if (n % 60 == 0) mode = int'($urandom_range(MODE_MIXED, MODE_GROW));
      case (mode)
        MODE_GROW:   begin ins_th = 55; del_th = 70; end
        MODE_SHRINK: begin ins_th = 15; del_th = 70; end
        default:     begin ins_th = 30; del_th = 60; end
      endcase
      w = int'($urandom_range(99));
      if (w < ins_th)                             op = OP_INSERT;
      else if (w < del_th)                        op = OP_DELETE;
      else if (w < del_th + (100 - del_th) / 2)   op = OP_SEARCH;
      else                                        op = OP_UPDATE;

      if ($urandom_range(99) < 15)  pos = PosW'($urandom_range(31));
      else if (op == OP_INSERT)     pos = PosW'($urandom_range(list_len + 1, 1));
      else if (list_len == 0)       pos = PosW'(1);
      else                          pos = PosW'($urandom_range(list_len, 1));

      // Favor values already held so search and update mostly hit.
      if (op != OP_INSERT && list_len > 0 && $urandom_range(99) < 70)
        val = list_mem[$urandom_range(list_len - 1)];
      else if ($urandom_range(99) < 60)
        val = value_pool[3'($urandom_range(7))];
      else
        val = $urandom;
      nval = ($urandom_range(1) == 1) ? value_pool[3'($urandom_range(7))] : $urandom;

      send_list_op(op, pos, val, nval, 1'b0, typed);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
